// ===== rtl/core/lru_kvc_pkg.sv =====
package lru_kvc_pkg;

  // Geometry
  localparam int DEPTH       = 64;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(DEPTH + 1);

  // Capacity register
  localparam int CAP_BITS    = 7;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(64);

  // Input queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [KEY_BITS-1:0]   lookup_key;
    logic [VALUE_BITS-1:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
  } out_word_t;

  // Head of the input queue as seen by the execute side
  typedef struct packed {
    logic     valid;
    in_word_t word;
  } q_head_t;

  // Index of the set bit in a one-hot (or zero) entry vector
  function automatic logic [IDX_BITS-1:0] onehot_to_idx(input logic [DEPTH-1:0] oh);
    logic [IDX_BITS-1:0] idx;
    idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (oh[i]) begin
        idx = idx | IDX_BITS'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/core/lru_kvc_ram.sv =====
module lru_kvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AddrBits-1:0] wr_addr,
  input  logic [WIDTH-1:0]    wr_data,
  input  logic [AddrBits-1:0] rd_addr,
  output logic [WIDTH-1:0]    rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/lru_kvc_front.sv =====
module lru_kvc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lru_kvc_pkg::in_word_t in_data,
  input  logic                  pop,
  output lru_kvc_pkg::q_head_t  head
);
  import lru_kvc_pkg::*;

  in_word_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 push;
  logic                 pop_ok;

  // Stall only on a full queue
  assign in_stall = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop_ok   = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.word  = slot_q[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_q[wr_ptr] <= in_data;
    end
  end

endmodule

// ===== rtl/core/lru_kvc_back.sv =====
module lru_kvc_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [lru_kvc_pkg::CAP_BITS-1:0]    cfg_wr_data,
  input  lru_kvc_pkg::q_head_t                head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lru_kvc_pkg::out_word_t              out_data
);
  import lru_kvc_pkg::*;

  typedef enum logic {S_LOOK, S_EXEC} state_t;

  state_t state;

  // Entry state
  logic [KEY_BITS-1:0] key_q  [DEPTH];
  logic [IDX_BITS-1:0] rank_q [DEPTH];
  logic [DEPTH-1:0]    valid_q;
  logic [CNT_BITS-1:0] occ_q;
  logic [CAP_BITS-1:0] capacity_q;

  // Look-up results held for the execute cycle
  in_word_t            cmd_q;
  logic [DEPTH-1:0]    match_q;
  logic                hit_q;
  logic [IDX_BITS-1:0] hit_idx_q;
  logic [IDX_BITS-1:0] hit_rank_q;
  logic [DEPTH-1:0]    victim_q;
  logic [DEPTH-1:0]    evict_q;
  logic                full_q;

  // Combinational look-up
  logic [DEPTH-1:0]    match;
  logic [DEPTH-1:0]    oldest;
  logic [IDX_BITS-1:0] match_idx;
  logic [IDX_BITS-1:0] hit_rank;
  logic [IDX_BITS-1:0] occ_last;
  logic [31:0]         cap_ext;
  logic [31:0]         eff_cap;
  logic                full;

  // Execute
  logic                out_free;
  logic                is_set;
  logic                exec_fire;
  logic                upd_touch;
  logic                upd_insert;
  logic [DEPTH-1:0]    slot_oh;
  logic [IDX_BITS-1:0] slot_idx;
  logic                ram_wr_en;
  logic [IDX_BITS-1:0] ram_wr_addr;
  logic [IDX_BITS-1:0] ram_rd_addr;
  logic [VALUE_BITS-1:0] ram_rd_data;

  // Effective capacity, clamped to 1 .. DEPTH
  assign cap_ext  = 32'(capacity_q);
  assign eff_cap  = (cap_ext == 32'd0) ? 32'd1 :
                    ((cap_ext > 32'(DEPTH)) ? 32'(DEPTH) : cap_ext);
  assign full     = (32'(occ_q) >= eff_cap);
  assign occ_last = IDX_BITS'(occ_q - 1'b1);

  // Associative compare against the queue head, oldest entry search
  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match[i]  = valid_q[i] && (key_q[i] == head.word.lookup_key);
      oldest[i] = valid_q[i] && (rank_q[i] == occ_last);
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        hit_rank = hit_rank | rank_q[i];
      end
    end
  end

  assign match_idx = onehot_to_idx(match);

  assign pop        = (state == S_LOOK) && head.valid;
  assign out_free   = !out_valid || !out_stall;
  assign is_set     = (cmd_q.op == OP_SET);
  assign exec_fire  = (state == S_EXEC) && (is_set || out_free);
  assign upd_touch  = exec_fire && hit_q;
  assign upd_insert = exec_fire && is_set && !hit_q;

  // Lowest free slot, the evicted one included
  assign slot_oh  = victim_q & (~victim_q + DEPTH'(1));
  assign slot_idx = onehot_to_idx(slot_oh);

  // Value store
  assign ram_wr_en   = exec_fire && is_set;
  assign ram_wr_addr = hit_q ? hit_idx_q : slot_idx;
  assign ram_rd_addr = (state == S_LOOK) ? match_idx : hit_idx_q;

  lru_kvc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (cmd_q.write_value),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOOK;
      out_valid <= 1'b0;
    end else begin
      if (exec_fire && !is_set) begin
        out_valid           <= 1'b1;
        out_data.hit        <= hit_q;
        out_data.read_value <= hit_q ? ram_rd_data : '0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOOK: begin
          if (head.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            state <= S_LOOK;
          end
        end
        default: state <= S_LOOK;
      endcase
    end
  end

  // Valid bits, recency ranks, occupancy, capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q    <= '0;
      occ_q      <= '0;
      capacity_q <= CAP_RESET;
      for (int i = 0; i < DEPTH; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        capacity_q <= cfg_wr_data;
      end
      if (upd_touch) begin
        // hit: entries newer than it age by one
        for (int i = 0; i < DEPTH; i++) begin
          if (match_q[i]) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank_q)) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
      end else if (upd_insert) begin
        // miss on set: drop the oldest when full, then insert as newest
        for (int i = 0; i < DEPTH; i++) begin
          valid_q[i] <= slot_oh[i] || (valid_q[i] && !evict_q[i]);
          if (slot_oh[i] || evict_q[i]) begin
            rank_q[i] <= '0;
          end else if (valid_q[i]) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
        if (!full_q) begin
          occ_q <= occ_q + 1'b1;
        end
      end
    end
  end

  // Look-up capture and key store
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_q      <= head.word;
      match_q    <= match;
      hit_q      <= |match;
      hit_idx_q  <= match_idx;
      hit_rank_q <= hit_rank;
      full_q     <= full;
      victim_q   <= ~valid_q | (full ? oldest : '0);
      evict_q    <= full ? oldest : '0;
    end
    if (upd_insert) begin
      key_q[slot_idx] <= cmd_q.lookup_key;
    end
  end

  // Keys are unique among valid entries
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    head.valid |-> $onehot0(match))
    else $error("more than one entry matches the key");

  // Occupancy tracks the valid bits
  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy disagrees with valid bits");

  // A set that misses always finds a slot
  a_slot_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && is_set && !hit_q) |-> (slot_oh != '0))
    else $error("no free slot for insert");

  // A finished get always presents its word
  a_get_result: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && !is_set) |=> out_valid)
    else $error("get finished without a result word");

endmodule

// ===== rtl/core/lru_key_value_cache.sv =====
// Fully associative key/value cache with least-recently-used replacement,
// DEPTH entries of KEY_BITS keys and VALUE_BITS values. A get (op 0)
// returns one word: hit and the stored value, or hit 0 and value 0; a set
// (op 1) updates or inserts and returns nothing. Input words land in a
// two-deep queue; the execute side takes one word at a time: a look-up
// cycle that compares the key against every stored key at once, then an
// execute cycle that updates the recency ranks, key and value store. A
// get's execute waits while out_stall holds an earlier word, then
// registers its word onto out. The capacity register (1 .. DEPTH, 0 reads
// as 1, larger as DEPTH) is to be written through cfg_wr_en/cfg_wr_data
// only while the block is idle, not enforced by the block; lowering it
// evicts one entry per later inserting set, never at once.
module lru_key_value_cache (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [lru_kvc_pkg::CAP_BITS-1:0] cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lru_kvc_pkg::in_word_t            in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lru_kvc_pkg::out_word_t           out_data
);
  import lru_kvc_pkg::*;

  q_head_t head;
  logic    pop;

  // Input queue
  lru_kvc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .pop      (pop),
    .head     (head)
  );

  // Look-up and update engine
  lru_kvc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ===== bench/lru_cache_check_pkg.sv =====
`timescale 1ns / 100ps
package lru_cache_check_pkg;
  import lru_kvc_pkg::*;

  // Shadow copy of the cache plus the queue of read words still owed by the block
  class lru_cache_scoreboard;
    logic [KEY_BITS-1:0]   slot_key   [DEPTH];
    logic [VALUE_BITS-1:0] slot_value [DEPTH];
    bit                    slot_used  [DEPTH];
    int unsigned           slot_age   [DEPTH];
    int unsigned           fill;
    logic [CAP_BITS-1:0]   cap_reg;
    out_word_t             pending_reads [$];
    int unsigned           mismatches;
    int unsigned           gets_hit;
    int unsigned           gets_missed;
    int unsigned           sets_seen;
    int unsigned           evictions;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_age[i]  = 0;
      end
      fill        = 0;
      cap_reg     = CAP_RESET;
      mismatches  = 0;
      gets_hit    = 0;
      gets_missed = 0;
      sets_seen   = 0;
      evictions   = 0;
    endfunction

    function void set_capacity(logic [CAP_BITS-1:0] v);
      cap_reg = v;
    endfunction

    // 0 behaves as 1, anything above the entry count as the entry count
    function int unsigned usable_capacity();
      if (cap_reg == 0) return 1;
      if (cap_reg > DEPTH) return DEPTH;
      return cap_reg;
    endfunction

    // Bring slot s to the front; every newer entry ages by one
    function void promote(int s);
      int unsigned r;
      r = slot_age[s];
      for (int i = 0; i < DEPTH; i++)
        if (slot_used[i] && slot_age[i] < r) slot_age[i]++;
      slot_age[s] = 0;
    endfunction

    function int locate(logic [KEY_BITS-1:0] k);
      for (int i = 0; i < DEPTH; i++)
        if (slot_used[i] && slot_key[i] == k) return i;
      return -1;
    endfunction

    function void drop_oldest();
      int victim;
      victim = -1;
      for (int i = 0; i < DEPTH; i++)
        if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
      if (victim >= 0) begin
        slot_used[victim] = 1'b0;
        slot_age[victim]  = 0;
        fill--;
        evictions++;
      end
    endfunction

    // New pair goes to the lowest free slot as the most recent entry
    function void place(logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
      int free_slot;
      free_slot = -1;
      for (int i = 0; i < DEPTH; i++)
        if (!slot_used[i] && free_slot < 0) free_slot = i;
      if (free_slot < 0) return;
      for (int i = 0; i < DEPTH; i++)
        if (slot_used[i]) slot_age[i]++;
      slot_key[free_slot]   = k;
      slot_value[free_slot] = v;
      slot_used[free_slot]  = 1'b1;
      slot_age[free_slot]   = 0;
      fill++;
    endfunction

    // Accepted input word: update the shadow and owe a read word for a get
    function void note_word(in_word_t w);
      int        s;
      out_word_t owed;
      s = locate(w.lookup_key);
      if (w.op == OP_GET) begin
        owed.hit        = (s >= 0);
        owed.read_value = '0;
        if (s >= 0) begin
          promote(s);
          owed.read_value = slot_value[s];
          gets_hit++;
        end else begin
          gets_missed++;
        end
        pending_reads = {pending_reads, owed};
      end else begin
        sets_seen++;
        if (s >= 0) begin
          slot_value[s] = w.write_value;
          promote(s);
        end else begin
          if (fill >= usable_capacity()) drop_oldest();
          place(w.lookup_key, w.write_value);
        end
      end
    endfunction

    function void report(string what, out_word_t want, out_word_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] %s: expected hit %0b value %08h, got hit %0b value %08h",
                 $time, what, want.hit, want.read_value, got.hit, got.read_value);
    endfunction

    // Accepted output word against the oldest one owed
    function void check_word(out_word_t got);
      out_word_t want;
      if (pending_reads.size() == 0) begin
        want = '0;
        report("read word with nothing outstanding", want, got);
        return;
      end
      want = pending_reads.pop_front();
      if (got.hit !== want.hit || got.read_value !== want.read_value)
        report("read word mismatch", want, got);
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import lru_kvc_pkg::*;
  import lru_cache_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES = 10;
  localparam int PHASE_WORDS = 165;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [CAP_BITS-1:0] cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_word_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_word_t           out_data;

  lru_cache_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int          burst_left = 0;
  int          cap_writes = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  lru_key_value_cache DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // Watchdog, output check and receiver stall pattern
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end else begin
      if (!rst && out_valid && !out_stall) sb.check_word(out_data);
      if (stall_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(8, 60);
      end
      stall_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:     out_stall <= (cycle_count[1:0] != 2'd0);
      endcase
    end
  end

  // Present one word, in bursts with random gaps, and hold it until taken
  task automatic push_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
    burst_left--;
  endtask

  task automatic send(input logic op, input logic [KEY_BITS-1:0] k,
                      input logic [VALUE_BITS-1:0] v);
    in_word_t w;
    w.op          = op;
    w.lookup_key  = k;
    w.write_value = v;
    push_word(w);
  endtask

  // Hold off until every owed read word is back and the last set has settled
  task automatic drain_block();
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending_reads.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_capacity(v);
    cap_writes++;
  endtask

  // Random traffic: mostly keys from a pool of capacity + capacity/4 + 2
  // keys, some one-bit neighbours of pool keys and some fully random keys
  task automatic run_phase(input int words);
    logic [KEY_BITS-1:0] key_pool [$];
    logic [KEY_BITS-1:0] k;
    int                  pool_size;
    int                  pick;
    pool_size = sb.usable_capacity() + sb.usable_capacity() / 4 + 2;
    repeat (pool_size) begin
      k        = $urandom;
      key_pool = {key_pool, k};
    end
    repeat (words) begin
      pick = $urandom_range(0, 19);
      k    = key_pool[$urandom_range(0, pool_size - 1)];
      if (pick < 3) k = $urandom;
      else if (pick < 5) k = k ^ (32'd1 << $urandom_range(0, 31));
      send(($urandom_range(0, 9) < 6) ? OP_SET : OP_GET, k, $urandom);
    end
  endtask

  initial begin
    logic [CAP_BITS-1:0] cap_plan [PHASES];
    int unsigned         failures;
    cap_plan = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd100, 7'd5, 7'd64, 7'd3, 7'd33, 7'd64};
    cap_plan[8] = CAP_BITS'($urandom_range(2, 63));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty cache, extreme keys and values, update in place
    send(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send(OP_SET, 32'h0000_0000, 32'h0000_0000);
    send(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send(OP_GET, 32'h0000_0001, 32'h0000_0000);
    send(OP_SET, 32'h0000_0000, 32'hA5A5_A5A5);
    send(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send(OP_SET, 32'h8000_0000, 32'h0000_0001);
    send(OP_GET, 32'h8000_0000, 32'h5A5A_5A5A);
    send(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);

    // Capacity lowered under the occupancy: one eviction per new key
    drain_block();
    write_capacity(7'd2);
    send(OP_SET, 32'h1234_5678, 32'h0000_0005);
    send(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send(OP_SET, 32'hDEAD_BEEF, 32'h0000_0006);
    send(OP_GET, 32'h8000_0000, 32'h0000_0000);

    // Capacity zero behaves as one
    drain_block();
    write_capacity(7'd0);
    send(OP_SET, 32'h5555_5555, 32'h0000_0007);
    send(OP_SET, 32'hAAAA_AAAA, 32'h0000_0008);
    send(OP_GET, 32'h5555_5555, 32'h0000_0000);
    send(OP_GET, 32'hAAAA_AAAA, 32'h0000_0000);
    send(OP_GET, 32'hDEAD_BEEF, 32'h0000_0000);

    for (int p = 0; p < PHASES; p++) begin
      drain_block();
      write_capacity(cap_plan[p]);
      run_phase(PHASE_WORDS);
    end
    drain_block();

    failures = sb.mismatches + sb.pending_reads.size();
    $display("Covered %0d gets (%0d hits, %0d misses) and %0d sets with %0d evictions,",
             sb.gets_hit + sb.gets_missed, sb.gets_hit, sb.gets_missed, sb.sets_seen,
             sb.evictions);
    $display("over %0d capacity writes from 0 to 127, %0d mismatches.",
             cap_writes, sb.mismatches);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lru_kvc_pkg.sv
rtl/core/lru_kvc_ram.sv
rtl/core/lru_kvc_front.sv
rtl/core/lru_kvc_back.sv
rtl/core/lru_key_value_cache.sv
bench/lru_cache_check_pkg.sv
bench/tb_top.sv
